FILE: hdl/alpha_coverage_box_query_macros.svh
// Assertion macros used by the alpha coverage box query controller.
`ifndef ALPHA_COVERAGE_BOX_QUERY_MACROS_SVH
`define ALPHA_COVERAGE_BOX_QUERY_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ACBQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ACBQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/acbq_pkg.sv
// Package: shared types, codes and widths of the alpha coverage box query.
`default_nettype none

package acbq_pkg;

	localparam int CMD_W     = 2;
	localparam int PIX_W     = 8;
	localparam int COORD_W   = 18;
	localparam int DIM_W     = 9;
	localparam int SUM_W     = 17;
	localparam int CFG_IDX_W = 1;
	localparam int PAD_LOW   = 1;
	localparam int PAD_HIGH  = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_QUERY = 2'd2
	} cmd_t;

	localparam logic [CFG_IDX_W-1:0] REG_MASK_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MASK_HEIGHT = 1'b1;

	// Corner read order; the first two add, the last two subtract.
	localparam logic [1:0] CORNER_Y1_X1 = 2'd0;
	localparam logic [1:0] CORNER_Y0_X0 = 2'd1;
	localparam logic [1:0] CORNER_Y0_X1 = 2'd2;
	localparam logic [1:0] CORNER_Y1_X0 = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LD_RD,
		ST_LD_WR,
		ST_Q_CVT,
		ST_Q_BND,
		ST_Q_RD,
		ST_Q_WAIT,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic       item_take;
		logic       restart;
		logic       ld_rd;
		logic       ld_wr;
		logic       cvt_en;
		logic [1:0] cvt_idx;
		logic       bnd_en;
		logic       rd_en;
		logic [1:0] rd_corner;
		logic       out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic load_ok;
		logic mask_complete;
	} ctl_sts_t;

endpackage

`default_nettype wire

FILE: hdl/alpha_coverage_box_query.sv
// A query that is forced visible skips the scaling, clipping and corner reads and goes straight to the result.
// Throughput: one clear per cycle; a query or a pixel load holds off the next item until it finishes.
// Rate is set by the single RAM port (four corner reads, read then write per pixel)
// and by the one multiplier that scales the four coordinates in turn.
// Reset (arst_n, async low): dimensions back to 256 (clamped to the maximum), load position cleared, no mask loaded.
// The table memory is not cleared; a query needs a complete load before it reads it.
`default_nettype none

module alpha_coverage_box_query #(
	parameter int MAX_MASK_WIDTH      = 256,
	parameter int MAX_MASK_HEIGHT     = 256,
	parameter int COORD_FRACTION_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                write_en,
	input  logic [acbq_pkg::CFG_IDX_W-1:0]      reg_index,
	input  logic [acbq_pkg::DIM_W-1:0]          write_data,
	// item channel
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic [acbq_pkg::CMD_W-1:0]          command,
	input  logic [acbq_pkg::PIX_W-1:0]          pixel_value,
	input  logic signed [acbq_pkg::COORD_W-1:0] box_min_u,
	input  logic signed [acbq_pkg::COORD_W-1:0] box_min_v,
	input  logic signed [acbq_pkg::COORD_W-1:0] box_max_u,
	input  logic signed [acbq_pkg::COORD_W-1:0] box_max_v,
	input  logic                                coords_not_finite,
	// result channel
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic                                box_visible
);
	import acbq_pkg::*;

	// Flow per item:
	//   clear  - load position reset in the accept cycle, block stays idle.
	//   load   - read the entry above, then write above + running row count.
	//   query  - scale four coordinates through one multiplier, pad and clip
	//            the box, read four corners, compare the two diagonal sums.
	// A finished result sits in the output register; the next item is taken
	// while it waits, and only a second result waits for it to drain.

	ctl_cmd_t ctl_cmd;
	ctl_sts_t ctl_sts;

	acbq_ctrl u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item_valid),
		.item_stall       (item_stall),
		.command          (command),
		.coords_not_finite(coords_not_finite),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.sts              (ctl_sts),
		.cmd_o            (ctl_cmd)
	);

	acbq_dp #(
		.MAX_MASK_WIDTH     (MAX_MASK_WIDTH),
		.MAX_MASK_HEIGHT    (MAX_MASK_HEIGHT),
		.COORD_FRACTION_BITS(COORD_FRACTION_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.write_en         (write_en),
		.reg_index        (reg_index),
		.write_data       (write_data),
		.pixel_value      (pixel_value),
		.box_min_u        (box_min_u),
		.box_min_v        (box_min_v),
		.box_max_u        (box_max_u),
		.box_max_v        (box_max_v),
		.coords_not_finite(coords_not_finite),
		.cmd              (ctl_cmd),
		.sts              (ctl_sts),
		.box_visible      (box_visible)
	);

endmodule

`default_nettype wire

FILE: hdl/acbq_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none

module acbq_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/acbq_ctrl.sv
// Controller: sequencing FSM and output valid for the box query block.
`default_nettype none

`include "alpha_coverage_box_query_macros.svh"

module acbq_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic [acbq_pkg::CMD_W-1:0]     command,
	input  logic                           coords_not_finite,
	output logic                           result_valid,
	input  logic                           result_stall,
	input  acbq_pkg::ctl_sts_t             sts,
	output acbq_pkg::ctl_cmd_t             cmd_o
);
	import acbq_pkg::*;

	state_t     state_q;
	state_t     state_nxt;
	logic [1:0] cnt_q;
	logic       result_valid_q;
	logic       accept;
	logic       out_free;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign out_free   = !(result_valid_q && result_stall);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (command)
						CMD_LOAD: begin
							state_nxt = sts.load_ok ? ST_LD_RD : ST_IDLE;
						end
						CMD_QUERY: begin
							state_nxt = (coords_not_finite || !sts.mask_complete) ?
								ST_RESULT : ST_Q_CVT;
						end
						default: begin
							state_nxt = ST_IDLE;
						end
					endcase
				end
			end
			ST_LD_RD:  state_nxt = ST_LD_WR;
			ST_LD_WR:  state_nxt = ST_IDLE;
			ST_Q_CVT:  state_nxt = (cnt_q == 2'd3) ? ST_Q_BND : ST_Q_CVT;
			ST_Q_BND:  state_nxt = ST_Q_RD;
			ST_Q_RD:   state_nxt = (cnt_q == 2'd3) ? ST_Q_WAIT : ST_Q_RD;
			ST_Q_WAIT: state_nxt = ST_RESULT;
			ST_RESULT: state_nxt = out_free ? ST_IDLE : ST_RESULT;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd_o           = '0;
		cmd_o.item_take = accept;
		cmd_o.restart   = accept && (command == CMD_CLEAR);
		cmd_o.cvt_idx   = cnt_q;
		cmd_o.rd_corner = cnt_q;
		case (state_q)
			ST_LD_RD:  cmd_o.ld_rd    = 1'b1;
			ST_LD_WR:  cmd_o.ld_wr    = 1'b1;
			ST_Q_CVT:  cmd_o.cvt_en   = 1'b1;
			ST_Q_BND:  cmd_o.bnd_en   = 1'b1;
			ST_Q_RD:   cmd_o.rd_en    = 1'b1;
			ST_RESULT: cmd_o.out_load = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_Q_CVT || state_q == ST_Q_RD) begin
				cnt_q <= cnt_q + 2'd1;
			end else begin
				cnt_q <= '0;
			end
			if (cmd_o.out_load) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;

	`ACBQ_ASSERT_SAME(a_no_overwrite, clk, arst_n, cmd_o.out_load, !(result_valid_q && result_stall), "result overwritten while stalled")
	`ACBQ_ASSERT_NEXT(a_forced_query, clk, arst_n, accept && (command == CMD_QUERY) && (coords_not_finite || !sts.mask_complete), state_q == ST_RESULT, "forced query did not answer at once")
	`ACBQ_ASSERT_NEXT(a_skip_load, clk, arst_n, accept && (command == CMD_LOAD) && !sts.load_ok, state_q == ST_IDLE, "ignored load touched the table")
	`ACBQ_ASSERT_NEXT(a_rd_done, clk, arst_n, (state_q == ST_Q_RD) && (cnt_q == 2'd3), state_q == ST_Q_WAIT, "corner reads overran")

endmodule

`default_nettype wire

FILE: hdl/acbq_dp.sv
// Datapath: load counters, coordinate scaling, corner reads and compare.
`default_nettype none

module acbq_dp #(
	parameter int MAX_MASK_WIDTH      = 256,
	parameter int MAX_MASK_HEIGHT     = 256,
	parameter int COORD_FRACTION_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   write_en,
	input  logic [acbq_pkg::CFG_IDX_W-1:0]         reg_index,
	input  logic [acbq_pkg::DIM_W-1:0]             write_data,
	input  logic [acbq_pkg::PIX_W-1:0]             pixel_value,
	input  logic signed [acbq_pkg::COORD_W-1:0]    box_min_u,
	input  logic signed [acbq_pkg::COORD_W-1:0]    box_min_v,
	input  logic signed [acbq_pkg::COORD_W-1:0]    box_max_u,
	input  logic signed [acbq_pkg::COORD_W-1:0]    box_max_v,
	input  logic                                   coords_not_finite,
	input  acbq_pkg::ctl_cmd_t                     cmd,
	output acbq_pkg::ctl_sts_t                     sts,
	output logic                                   box_visible
);
	import acbq_pkg::*;

	localparam int COL_AW    = (MAX_MASK_WIDTH > 1) ? $clog2(MAX_MASK_WIDTH) : 1;
	localparam int ROW_AW    = (MAX_MASK_HEIGHT > 1) ? $clog2(MAX_MASK_HEIGHT) : 1;
	localparam int ADDR_W    = ROW_AW + COL_AW;
	localparam int RAM_DEPTH = 2 ** ADDR_W;
	localparam int QW        = COORD_W - 1;
	localparam int COORD_MAX = (1 << QW) - 1;
	localparam int ONE_LIM   = (COORD_FRACTION_BITS >= QW) ? COORD_MAX :
		(1 << COORD_FRACTION_BITS);
	localparam int PROD_W    = QW + DIM_W;
	localparam int EXT_W     = DIM_W + 1;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
		input int maxv);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (int'(v) > maxv) begin
			r = DIM_W'(maxv);
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] addr_of(input logic [DIM_W-1:0] row,
		input logic [DIM_W-1:0] col);
		return {ROW_AW'(row), COL_AW'(col)};
	endfunction

	// configuration and load state
	logic [DIM_W-1:0] width_q, height_q;
	logic [DIM_W-1:0] row_q, col_q, count_q;
	logic             complete_q;

	// captured item
	logic                      nz_q;
	logic                      forced_q;
	logic signed [COORD_W-1:0] coord_q [4];

	// query pipeline
	logic [DIM_W-1:0] cell_q [4];
	logic [DIM_W-1:0] x0_q, y0_q, x1_q, y1_q;
	logic [SUM_W-1:0] corner_q [4];
	logic             rd_pend_s1;
	logic [1:0]       rd_corner_s1;
	logic             rd_zero_s1;
	logic             box_visible_q;

	// combinational
	logic [DIM_W-1:0]  col_nxt, row_nxt, count_nxt;
	logic [SUM_W-1:0]  above, wsum;
	logic signed [COORD_W-1:0] coord_sel;
	logic [QW-1:0]     q_clamp;
	logic [DIM_W-1:0]  size_m1;
	logic [PROD_W-1:0] prod;
	logic [DIM_W-1:0]  cell_val;
	logic [DIM_W-1:0]  x0_d, y0_d, x1_d, y1_d;
	logic [EXT_W-1:0]  x1_ext, y1_ext;
	logic [DIM_W-1:0]  y_sel, x_sel;
	logic              rd_zero;
	logic [SUM_W:0]    pos_sum, neg_sum;

	logic              ram_en, ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [SUM_W-1:0]  ram_rdata;

	// configuration registers, stored already clamped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= clamp_dim(DIM_W'(256), MAX_MASK_WIDTH);
			height_q <= clamp_dim(DIM_W'(256), MAX_MASK_HEIGHT);
		end else if (write_en) begin
			case (reg_index)
				REG_MASK_WIDTH:  width_q  <= clamp_dim(write_data, MAX_MASK_WIDTH);
				default:         height_q <= clamp_dim(write_data, MAX_MASK_HEIGHT);
			endcase
		end
	end

	// load sequencing
	assign col_nxt   = col_q + DIM_W'(1);
	assign row_nxt   = row_q + DIM_W'(1);
	assign count_nxt = count_q + DIM_W'(nz_q);
	assign above     = (row_q == '0) ? '0 : ram_rdata;
	assign wsum      = above + SUM_W'(count_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q      <= '0;
			col_q      <= '0;
			count_q    <= '0;
			complete_q <= 1'b0;
		end else if (write_en || cmd.restart) begin
			row_q      <= '0;
			col_q      <= '0;
			count_q    <= '0;
			complete_q <= 1'b0;
		end else if (cmd.ld_wr) begin
			if (col_nxt >= width_q) begin
				col_q   <= '0;
				count_q <= '0;
				row_q   <= row_nxt;
				if (row_nxt >= height_q) begin
					complete_q <= 1'b1;
				end
			end else begin
				col_q   <= col_nxt;
				count_q <= count_nxt;
			end
		end
	end

	assign sts.load_ok       = !complete_q && (row_q < height_q) && (col_q < width_q);
	assign sts.mask_complete = complete_q;

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.item_take) begin
			nz_q       <= |pixel_value;
			forced_q   <= coords_not_finite | !complete_q;
			coord_q[0] <= box_min_u;
			coord_q[1] <= box_min_v;
			coord_q[2] <= box_max_u;
			coord_q[3] <= box_max_v;
		end
	end

	// coordinate to cell: clamp, scale by size-1, truncate
	assign coord_sel = coord_q[cmd.cvt_idx];
	always_comb begin
		if (coord_sel[COORD_W-1]) begin
			q_clamp = '0;
		end else if (int'(coord_sel[QW-1:0]) > ONE_LIM) begin
			q_clamp = QW'(ONE_LIM);
		end else begin
			q_clamp = coord_sel[QW-1:0];
		end
	end
	assign size_m1  = (cmd.cvt_idx[0] ? height_q : width_q) - DIM_W'(1);
	assign prod     = PROD_W'(q_clamp) * PROD_W'(size_m1);
	assign cell_val = DIM_W'(prod >> COORD_FRACTION_BITS);

	always_ff @(posedge clk) begin
		if (cmd.cvt_en) begin
			cell_q[cmd.cvt_idx] <= cell_val;
		end
	end

	// padding and clipping
	assign x0_d   = (cell_q[0] == '0) ? '0 : cell_q[0] - DIM_W'(PAD_LOW);
	assign y0_d   = (cell_q[1] == '0) ? '0 : cell_q[1] - DIM_W'(PAD_LOW);
	assign x1_ext = EXT_W'(cell_q[2]) + EXT_W'(PAD_HIGH);
	assign y1_ext = EXT_W'(cell_q[3]) + EXT_W'(PAD_HIGH);
	assign x1_d   = (x1_ext < EXT_W'(width_q)) ? DIM_W'(x1_ext) : width_q;
	assign y1_d   = (y1_ext < EXT_W'(height_q)) ? DIM_W'(y1_ext) : height_q;

	always_ff @(posedge clk) begin
		if (cmd.bnd_en) begin
			x0_q <= x0_d;
			y0_q <= y0_d;
			x1_q <= x1_d;
			y1_q <= y1_d;
		end
	end

	// corner select; row zero and column zero read as zero
	always_comb begin
		case (cmd.rd_corner)
			CORNER_Y1_X1: begin y_sel = y1_q; x_sel = x1_q; end
			CORNER_Y0_X0: begin y_sel = y0_q; x_sel = x0_q; end
			CORNER_Y0_X1: begin y_sel = y0_q; x_sel = x1_q; end
			default:      begin y_sel = y1_q; x_sel = x0_q; end
		endcase
	end
	assign rd_zero = (y_sel == '0) || (x_sel == '0);

	// single RAM port: load read, load write or corner read
	assign ram_en = cmd.ld_rd | cmd.ld_wr | cmd.rd_en;
	assign ram_we = cmd.ld_wr;
	always_comb begin
		if (cmd.ld_wr) begin
			ram_addr = addr_of(row_q, col_q);
		end else if (cmd.ld_rd) begin
			ram_addr = addr_of(row_q - DIM_W'(1), col_q);
		end else begin
			ram_addr = addr_of(y_sel - DIM_W'(1), x_sel - DIM_W'(1));
		end
	end

	acbq_ram #(
		.WIDTH(SUM_W),
		.DEPTH(RAM_DEPTH)
	) u_sums (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(wsum),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_s1 <= 1'b0;
		end else begin
			rd_pend_s1 <= cmd.rd_en;
		end
	end

	always_ff @(posedge clk) begin
		rd_corner_s1 <= cmd.rd_corner;
		rd_zero_s1   <= rd_zero;
		if (rd_pend_s1) begin
			corner_q[rd_corner_s1] <= rd_zero_s1 ? '0 : ram_rdata;
		end
	end

	// four-corner compare
	assign pos_sum = (SUM_W+1)'(corner_q[CORNER_Y1_X1]) + (SUM_W+1)'(corner_q[CORNER_Y0_X0]);
	assign neg_sum = (SUM_W+1)'(corner_q[CORNER_Y0_X1]) + (SUM_W+1)'(corner_q[CORNER_Y1_X0]);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			box_visible_q <= forced_q | (pos_sum > neg_sum);
		end
	end

	assign box_visible = box_visible_q;

endmodule

`default_nettype wire
